### rtl/multi_sensor_window_min_filter_defines.svh
`ifndef MULTI_SENSOR_WINDOW_MIN_FILTER_DEFINES_SVH
`define MULTI_SENSOR_WINDOW_MIN_FILTER_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define MSW_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define MSW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/msw_pkg.sv
`default_nettype none

package msw_pkg;

  localparam int NUM_SENSORS = 16;
  localparam int WINDOW_MAX  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int IDX_W      = 4;
  localparam int RANGE_W    = 16;
  localparam int CNT_W      = 5;
  localparam int WLEN_W     = 4;
  localparam int GROUP_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = CNT_W + 2;

  localparam int SENS_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int HEAD_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int ADDR_W = (NUM_SENSORS * WINDOW_MAX > 1) ?
                          $clog2(NUM_SENSORS * WINDOW_MAX) : 1;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RANGE_W-1:0] RESET_RANGE_MM = 16'd5675;
  localparam logic [RANGE_W-1:0] PHANTOM_MM     = 16'hFFFF;

  localparam logic [GROUP_W-1:0] GRP_FRONT   = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_SKEW    = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_SIDE    = 2'd2;
  localparam logic [GROUP_W-1:0] GRP_INVALID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRONT_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE     = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]   front_count;
    logic [CNT_W-1:0]   skew_count;
    logic [CNT_W-1:0]   side_count;
    logic [WLEN_W-1:0]  window_length;
    logic [RANGE_W-1:0] max_range_mm;
  } cfg_t;

  typedef struct packed {
    logic               round_start;
    logic [GROUP_W-1:0] group;
    logic [IDX_W-1:0]   sensor_index;
    logic [RANGE_W-1:0] range_mm;
  } item_t;

  // queue read side toward the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

  // slot wrap for a sum known to stay below twice the window depth
  function automatic logic [HEAD_W-1:0] wrap_slot(input logic [HEAD_W:0] s);
    logic [HEAD_W:0] r;
    begin
      r = s;
      if (s >= (HEAD_W+1)'(WINDOW_MAX)) r = s - (HEAD_W+1)'(WINDOW_MAX);
      return r[HEAD_W-1:0];
    end
  endfunction

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [SENS_W-1:0] sens,
                                                input logic [HEAD_W-1:0] slot);
    begin
      return ADDR_W'(int'(sens) * WINDOW_MAX + int'(slot));
    end
  endfunction

endpackage

`default_nettype wire

### rtl/msw_front.sv
`default_nettype none

module msw_front (
  input  wire msw_pkg::cfg_t cfg,
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire [23:0]         s_axis_tdata,
  input  wire                s_axis_tuser,
  input  wire                q_full,
  output logic               push,
  output msw_pkg::item_t     push_item
);

  logic [msw_pkg::SUM_W-1:0]   b1, b2, b3;
  logic [msw_pkg::IDX_W-1:0]   idx;
  logic [msw_pkg::GROUP_W-1:0] group;

  assign idx = s_axis_tdata[msw_pkg::IDX_W-1:0];

  assign b1 = msw_pkg::SUM_W'(cfg.front_count);
  assign b2 = b1 + msw_pkg::SUM_W'(cfg.skew_count);
  assign b3 = b2 + msw_pkg::SUM_W'(cfg.side_count);

  always_comb begin
    priority if (int'(idx) >= msw_pkg::NUM_SENSORS || msw_pkg::SUM_W'(idx) >= b3) begin
      group = msw_pkg::GRP_INVALID;
    end else if (msw_pkg::SUM_W'(idx) < b1) begin
      group = msw_pkg::GRP_FRONT;
    end else if (msw_pkg::SUM_W'(idx) < b2) begin
      group = msw_pkg::GRP_SKEW;
    end else begin
      group = msw_pkg::GRP_SIDE;
    end
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  always_comb begin
    push_item.round_start  = s_axis_tuser;
    push_item.group        = group;
    push_item.sensor_index = idx;
    push_item.range_mm     = s_axis_tdata[msw_pkg::IDX_W +: msw_pkg::RANGE_W];
  end

endmodule

`default_nettype wire

### rtl/msw_queue.sv
`default_nettype none

module msw_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire msw_pkg::item_t push_item,
  output logic               full,
  input  wire                pop,
  output msw_pkg::q_out_t    q_out
);

  msw_pkg::item_t             slots [msw_pkg::QUEUE_DEPTH];
  logic [msw_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [msw_pkg::QCNT_W-1:0] count;
  logic                       do_pop;

  assign full        = (count == msw_pkg::QCNT_W'(msw_pkg::QUEUE_DEPTH));
  assign q_out.valid = (count != '0);
  assign q_out.item  = slots[rd_ptr];
  assign do_pop      = pop && q_out.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == msw_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == msw_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/msw_back.sv
`default_nettype none
`include "multi_sensor_window_min_filter_defines.svh"

module msw_back (
  input  wire                clk,
  input  wire                rst,
  input  wire msw_pkg::cfg_t  cfg,
  input  wire msw_pkg::q_out_t q_out,
  output logic               pop,
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  output logic [63:0]        m_axis_tdata,
  output logic [1:0]         m_axis_tuser
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;

  logic [msw_pkg::RANGE_W-1:0] mem [msw_pkg::NUM_SENSORS * msw_pkg::WINDOW_MAX];
  logic [msw_pkg::FILL_W-1:0]  fill_arr [msw_pkg::NUM_SENSORS];
  logic [msw_pkg::HEAD_W-1:0]  head_arr [msw_pkg::NUM_SENSORS];
  logic [msw_pkg::NUM_SENSORS-1:0] phantom;

  msw_pkg::item_t             item_r;
  logic [msw_pkg::SENS_W-1:0] sens_r;
  logic [msw_pkg::HEAD_W-1:0] head_r;
  logic [msw_pkg::FILL_W-1:0] total_r, iss_cnt;
  logic [msw_pkg::RANGE_W-1:0] cur_min;

  logic                        rd_valid, rd_phantom;
  logic [msw_pkg::RANGE_W-1:0] rd_data, rd_eff;

  logic [msw_pkg::RANGE_W-1:0] fb_min, skew_min, side_min;

  logic [msw_pkg::RANGE_W-1:0] out_filt, out_fb, out_skew, out_side;
  logic [msw_pkg::GROUP_W-1:0] out_group;
  logic                        out_valid, out_free;

  // window trim for the item at the queue head
  logic [msw_pkg::SENS_W-1:0] q_sens;
  logic [msw_pkg::FILL_W-1:0] len_eff, fill_cur, fill_t, drop;
  logic [msw_pkg::HEAD_W-1:0] head_cur, head_t, wslot, rslot;
  logic                       issue;

  assign q_sens   = msw_pkg::SENS_W'(q_out.item.sensor_index);
  assign fill_cur = fill_arr[q_sens];
  assign head_cur = head_arr[q_sens];

  always_comb begin
    if (cfg.window_length == '0) begin
      len_eff = msw_pkg::FILL_W'(1);
    end else if (int'(cfg.window_length) > msw_pkg::WINDOW_MAX) begin
      len_eff = msw_pkg::FILL_W'(msw_pkg::WINDOW_MAX);
    end else begin
      len_eff = msw_pkg::FILL_W'(cfg.window_length);
    end
  end

  always_comb begin
    drop   = fill_cur - len_eff + 1'b1;
    head_t = head_cur;
    fill_t = fill_cur;
    if (fill_cur >= len_eff) begin
      head_t = msw_pkg::wrap_slot((msw_pkg::HEAD_W+1)'(head_cur) +
                                  (msw_pkg::HEAD_W+1)'(drop));
      fill_t = len_eff - 1'b1;
    end
    wslot = msw_pkg::wrap_slot((msw_pkg::HEAD_W+1)'(head_t) +
                               (msw_pkg::HEAD_W+1)'(fill_t));
  end

  assign pop      = (state == ST_IDLE) && q_out.valid;
  assign out_free = !out_valid || m_axis_tready;
  assign issue    = (state == ST_SCAN) && (iss_cnt != total_r);
  assign rslot    = msw_pkg::wrap_slot((msw_pkg::HEAD_W+1)'(head_r) +
                                       (msw_pkg::HEAD_W+1)'(iss_cnt));
  assign rd_eff   = rd_phantom ? msw_pkg::PHANTOM_MM : rd_data;

  // new reading goes in at pop; older entries are scanned one per cycle
  always_ff @(posedge clk) begin
    if (pop && q_out.item.group != msw_pkg::GRP_INVALID) begin
      mem[msw_pkg::mk_addr(q_sens, wslot)] <= q_out.item.range_mm;
    end
    rd_data <= mem[msw_pkg::mk_addr(sens_r, rslot)];
  end

  // result stage
  logic [msw_pkg::RANGE_W-1:0] filt, fb_new, skew_new, side_new;

  always_comb begin
    filt = (cur_min < cfg.max_range_mm) ? cur_min : cfg.max_range_mm;
    if (item_r.group == msw_pkg::GRP_INVALID) begin
      filt = '0;
    end
    fb_new   = fb_min;
    skew_new = skew_min;
    side_new = side_min;
    unique case (item_r.group)
      msw_pkg::GRP_FRONT: if (filt < fb_min)   fb_new   = filt;
      msw_pkg::GRP_SKEW:  if (filt < skew_min) skew_new = filt;
      msw_pkg::GRP_SIDE:  if (filt < side_min) side_new = filt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r  <= q_out.item;
      sens_r  <= q_sens;
      head_r  <= head_t;
      total_r <= fill_t;
      cur_min <= q_out.item.range_mm;
    end else if (rd_valid && rd_eff < cur_min) begin
      cur_min <= rd_eff;
    end
    rd_phantom <= issue && (rslot == '0) && phantom[sens_r];
    if (state == ST_DONE && out_free) begin
      out_filt  <= filt;
      out_group <= item_r.group;
      out_fb    <= fb_new;
      out_skew  <= skew_new;
      out_side  <= side_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iss_cnt   <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      phantom   <= '1;
      fb_min    <= msw_pkg::RESET_RANGE_MM;
      skew_min  <= msw_pkg::RESET_RANGE_MM;
      side_min  <= msw_pkg::RESET_RANGE_MM;
      for (int s = 0; s < msw_pkg::NUM_SENSORS; s++) begin
        fill_arr[s] <= msw_pkg::FILL_W'(1);
        head_arr[s] <= '0;
      end
    end else begin
      rd_valid <= issue;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            iss_cnt <= '0;
            if (q_out.item.round_start) begin
              fb_min   <= cfg.max_range_mm;
              skew_min <= cfg.max_range_mm;
              side_min <= cfg.max_range_mm;
            end
            if (q_out.item.group == msw_pkg::GRP_INVALID) begin
              state <= ST_DONE;
            end else begin
              fill_arr[q_sens] <= fill_t + 1'b1;
              head_arr[q_sens] <= head_t;
              if (wslot == '0) begin
                phantom[q_sens] <= 1'b0;
              end
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            iss_cnt <= iss_cnt + 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            fb_min    <= fb_new;
            skew_min  <= skew_new;
            side_min  <= side_new;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_group;
  assign m_axis_tdata  = {out_side, out_skew, out_fb, out_filt};

  `MSW_ASSERT_SAME(a_scan_bound, state == ST_SCAN, iss_cnt <= total_r,
                   "scan issued past window fill")
  `MSW_ASSERT_SAME(a_pop_idle, pop, state == ST_IDLE && q_out.valid,
                   "pop outside idle")
  `MSW_ASSERT_NEXT(a_done_loads, state == ST_DONE && out_free,
                   out_valid && state == ST_IDLE, "finished word not loaded")
  `MSW_ASSERT_SAME(a_invalid_zero, out_valid && out_group == msw_pkg::GRP_INVALID,
                   out_filt == '0, "invalid sensor word carries nonzero value")

endmodule

`default_nettype wire

### rtl/multi_sensor_window_min_filter.sv
`default_nettype none

// Per-sensor sliding-window minimum of range readings with front/back, skew and
// side group minima. Each input word gives one reading; each yields one output
// word. A front end classifies the sensor index into its group and queues the
// word (two deep); the back end writes the reading into the sensor's window
// memory and scans the older entries one per cycle through the single read
// port, while an invalid index is neither written nor scanned; a finished
// word may still wait on the output. The output register lets the next word
// enter while a result waits. Config registers should only be written while
// no word is in flight. No memory clearing pass is needed after reset.
module multi_sensor_window_min_filter (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [15:0] cfg_data,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [23:0] s_axis_tdata,  // sensor_index[3:0], range_mm[19:4], zero fill
  input  wire        s_axis_tuser,  // round_start
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [63:0] m_axis_tdata, // filtered_mm, front_back_min_mm, skew_min_mm,
                                    // side_min_mm (16 bits each)
  output logic [1:0] m_axis_tuser   // sensor_group
);

  msw_pkg::cfg_t   cfg;
  msw_pkg::item_t  push_item;
  msw_pkg::q_out_t q_out;
  logic            push, q_full, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_count   <= msw_pkg::CNT_W'(1);
      cfg.skew_count    <= '0;
      cfg.side_count    <= '0;
      cfg.window_length <= msw_pkg::WLEN_W'(4);
      cfg.max_range_mm  <= msw_pkg::RESET_RANGE_MM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msw_pkg::REG_FRONT_COUNT:   cfg.front_count   <= cfg_data[msw_pkg::CNT_W-1:0];
        msw_pkg::REG_SKEW_COUNT:    cfg.skew_count    <= cfg_data[msw_pkg::CNT_W-1:0];
        msw_pkg::REG_SIDE_COUNT:    cfg.side_count    <= cfg_data[msw_pkg::CNT_W-1:0];
        msw_pkg::REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[msw_pkg::WLEN_W-1:0];
        msw_pkg::REG_MAX_RANGE:     cfg.max_range_mm  <= cfg_data;
        default: ;
      endcase
    end
  end

  msw_front u_front (
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  msw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_out     (q_out)
  );

  msw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_out         (q_out),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
